@@ hw/rtl/sliding_window_median_defines.svh @@
// Assertion macros for the sliding window median filter.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// condition holds at every edge out of reset
`define SWM_CHECK(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SWM_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/swm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types for the sliding window median filter.
// No dependencies; used by the sorted cell and the top level.
package swm_pkg;

   // status one sorted cell shows its neighbors
   typedef struct packed {
      logic valid;  // holds a sample (after a sequence restart)
      logic lek;    // value <= incoming sample
      logic ltov;   // value < sample leaving the window
   } swm_flag_type;

   // per-transfer control broadcast to every cell
   typedef struct packed {
      logic en;     // input transfer this cycle
      logic wipe;   // register write empties the window
      logic clear;  // new sequence starts with this sample
      logic full;   // window completes, oldest sample leaves
      logic ov_lt;  // leaving sample below incoming one
      logic ov_gt;  // leaving sample above incoming one
   } swm_ctl_type;

endpackage

@@ hw/rtl/swm_sort_cell.sv @@
`timescale 1ns / 1ps
// One cell of the sorted sample row: holds a value and its valid bit.
// Depends on swm_pkg for the flag and control structs.
module swm_sort_cell import swm_pkg::*; #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_ctl_type                   ctl,
   input  logic signed [SAMPLE_BITS-1:0] key,
   input  logic signed [SAMPLE_BITS-1:0] ov,
   input  swm_flag_type                  left_flg,
   input  logic signed [SAMPLE_BITS-1:0] left_val,
   input  swm_flag_type                  right_flg,
   input  logic signed [SAMPLE_BITS-1:0] right_val,
   output swm_flag_type                  flg,
   output logic signed [SAMPLE_BITS-1:0] val
);

   logic signed [SAMPLE_BITS-1:0] val_ff, val_in;
   logic                          valid_ff, valid_in;
   logic                          v_eff;

   always_comb begin
      v_eff    = valid_ff & ~ctl.clear;
      flg.valid = v_eff;
      flg.lek   = v_eff && (val_ff <= key);
      flg.ltov  = v_eff && (val_ff < ov);
      val       = val_ff;
   end

   // Insert the new sample and, when the window completes, drop one copy of the
   // leaving sample. Only cells between the two positions move by one place.
   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      if (ctl.wipe) begin
         valid_in = 1'b0;
      end else if (ctl.en) begin
         valid_in = v_eff;
         if (!ctl.full) begin
            valid_in = v_eff | left_flg.valid;
            if (!flg.lek && left_flg.lek) begin
               val_in = key;
            end else if (!flg.lek && left_flg.valid) begin
               val_in = left_val;
            end
         end else if (ctl.ov_lt) begin
            if (!flg.ltov && right_flg.lek) begin
               val_in = right_val;
            end else if (flg.lek && !right_flg.lek) begin
               val_in = key;
            end
         end else if (ctl.ov_gt) begin
            if (!flg.lek && left_flg.lek) begin
               val_in = key;
            end else if (!left_flg.lek && left_flg.ltov) begin
               val_in = left_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

@@ hw/rtl/swm_delay_line.sv @@
`timescale 1ns / 1ps
// Arrival-order line of samples with one selectable tap.
// No dependencies; tap 0 holds the most recent sample.
module swm_delay_line #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int IW    = 6
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WIDTH-1:0] din,
   input  logic [IW-1:0]           tap_idx,
   output logic signed [WIDTH-1:0] tap
);

   logic signed [WIDTH-1:0] taps_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         taps_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
      end
   end

   assign tap = taps_ff[tap_idx];

endmodule

@@ hw/rtl/sliding_window_median.sv @@
`timescale 1ns / 1ps
// Sliding window median filter, top level. One sample per cycle while the input is not stalled;
// the median of a completing window is registered into the output in the cycle after the transfer.
// Every cell of the sorted row inserts and removes in the same cycle as its neighbors.
// The input stalls only while a held result is stalled.
// Synchronous reset empties the window and sets the length to one; no clearing pass.
`include "sliding_window_median_defines.svh"
module sliding_window_median import swm_pkg::*; #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_new_sequence,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_median,
   input  logic                          csr_we,
   input  logic [6:0]                    csr_wdata
);

   localparam int LW = $clog2(MAX_WINDOW + 1);
   localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   localparam swm_flag_type LEFT_EDGE  = '{valid: 1'b1, lek: 1'b1, ltov: 1'b1};
   localparam swm_flag_type RIGHT_EDGE = '{valid: 1'b0, lek: 1'b0, ltov: 1'b0};

   logic [LW-1:0] len_ff, len_in;
   logic [IW-1:0] med_idx_ff, med_idx_in, med_prev;
   logic [IW-1:0] tap_idx_ff, tap_idx_in;
   logic          len_one_ff, len_one_in;
   logic [LW-1:0] fill_ff, fill_eff;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff, median;
   logic signed [SAMPLE_BITS-1:0] ov, tap;
   logic                          accept;
   swm_ctl_type                   ctl;

   swm_flag_type                  cell_flg [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]         valid_vec;
   logic                          fill_match;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign accept     = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

   // length register: zero acts as one, oversize as the row length
   always_comb begin
      if (csr_wdata == '0) begin
         len_in = LW'(1);
      end else if (int'(csr_wdata) > MAX_WINDOW) begin
         len_in = LW'(MAX_WINDOW);
      end else begin
         len_in = LW'(csr_wdata);
      end
      med_idx_in = IW'((len_in - 1'b1) >> 1);
      tap_idx_in = IW'(len_in - LW'(2));
      len_one_in = (len_in == LW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= LW'(1);
         med_idx_ff <= '0;
         tap_idx_ff <= '0;
         len_one_ff <= 1'b1;
      end else if (csr_we) begin
         len_ff     <= len_in;
         med_idx_ff <= med_idx_in;
         tap_idx_ff <= tap_idx_in;
         len_one_ff <= len_one_in;
      end
   end

   swm_delay_line #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW),
      .IW    (IW)
   ) u_arrival (
      .clock   (clock),
      .en      (accept),
      .din     (req_sample),
      .tap_idx (tap_idx_ff),
      .tap     (tap)
   );

   // sample leaving the window once this one is in
   assign ov       = len_one_ff ? req_sample : tap;
   assign fill_eff = req_new_sequence ? '0 : fill_ff;

   always_comb begin
      ctl.en    = accept;
      ctl.wipe  = csr_we;
      ctl.clear = accept & req_new_sequence;
      ctl.full  = (fill_eff == len_ff - 1'b1);
      ctl.ov_lt = ov < req_sample;
      ctl.ov_gt = ov > req_sample;
   end

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      swm_flag_type                  l_flg, r_flg;
      logic signed [SAMPLE_BITS-1:0] l_val, r_val;

      if (i == 0) begin : g_first
         assign l_flg = LEFT_EDGE;
         assign l_val = '0;
      end else begin : g_inner_l
         assign l_flg = cell_flg[i-1];
         assign l_val = cell_val[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_last
         assign r_flg = RIGHT_EDGE;
         assign r_val = '0;
      end else begin : g_inner_r
         assign r_flg = cell_flg[i+1];
         assign r_val = cell_val[i+1];
      end

      swm_sort_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .key       (req_sample),
         .ov        (ov),
         .left_flg  (l_flg),
         .left_val  (l_val),
         .right_flg (r_flg),
         .right_val (r_val),
         .flg       (cell_flg[i]),
         .val       (cell_val[i])
      );

      assign valid_vec[i] = cell_flg[i].valid;
   end

   // rank med_idx of the row with the new sample inserted
   assign med_prev = med_idx_ff - 1'b1;
   always_comb begin
      if (cell_flg[med_idx_ff].lek) begin
         median = cell_val[med_idx_ff];
      end else if ((med_idx_ff == '0) || cell_flg[med_prev].lek) begin
         median = req_sample;
      end else begin
         median = cell_val[med_prev];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (csr_we) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= ctl.full ? fill_eff : fill_eff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && ctl.full) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && ctl.full) begin
         rsp_median_ff <= median;
      end
   end

   assign fill_match = ($countones(valid_vec) == int'(fill_ff));

   `SWM_CHECK(a_fill_below_len, fill_ff < len_ff, "fill count reached window length")
   `SWM_CHECK(a_valid_matches_fill, accept || fill_match, "valid bits disagree with fill count")
   `SWM_CHECK_NEXT(a_result_follows, accept && ctl.full, rsp_valid_ff, "missing result")

endmodule
